### rtl/core/fwrm_pkg.sv
package fwrm_pkg;

  localparam int unsigned AddrBitsW  = 32;
  localparam int unsigned PortBitsW  = 16;
  localparam int unsigned RulesHeldW = 7;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_CHECK = 2'd2
  } fwrm_func_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } fwrm_state_e;

  typedef struct packed {
    logic [1:0]           func;
    logic [AddrBitsW-1:0] rule_addr_low;
    logic [AddrBitsW-1:0] rule_addr_high;
    logic [PortBitsW-1:0] rule_port_low;
    logic [PortBitsW-1:0] rule_port_high;
    logic [AddrBitsW-1:0] pkt_addr;
    logic [PortBitsW-1:0] pkt_port;
  } fwrm_in_t;

  typedef struct packed {
    logic                  reject;
    logic                  table_full;
    logic [RulesHeldW-1:0] rules_held;
  } fwrm_out_t;

  typedef struct packed {
    logic [AddrBitsW-1:0] addr_low;
    logic [AddrBitsW-1:0] addr_high;
    logic [PortBitsW-1:0] port_low;
    logic [PortBitsW-1:0] port_high;
  } fwrm_rule_t;

  typedef struct packed {
    logic [AddrBitsW-1:0] addr;
    logic [PortBitsW-1:0] port;
  } fwrm_pkt_t;

  localparam int unsigned RuleW = $bits(fwrm_rule_t);

endpackage

### rtl/core/fwrm_ram.sv
module fwrm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/fwrm_match.sv
module fwrm_match
  import fwrm_pkg::*;
(
  input  fwrm_rule_t rule_i,
  input  fwrm_pkt_t  pkt_i,
  output logic       hit_o
);

  logic addr_in, port_in;

  // Inverted bounds fall out naturally: no value satisfies both compares.
  assign addr_in = (pkt_i.addr >= rule_i.addr_low) && (pkt_i.addr <= rule_i.addr_high);
  assign port_in = (pkt_i.port >= rule_i.port_low) && (pkt_i.port <= rule_i.port_high);
  assign hit_o   = addr_in && port_in;

endmodule

### rtl/core/firewall_rule_range_match.sv
// Firewall rule table with range match. Rules (inclusive address and port
// ranges) live in one single-port-read rule memory of MAX_RULES entries. Clear
// and add go straight from idle to the done state. A check reads one rule per
// cycle through the single read port of the memory and stops at the first
// covering rule or after the last stored rule; with an empty table it goes
// straight to the done state. No clearing pass is needed after reset: only
// entries below the rule count are ever read. A finished result sits in an
// output register, so the next beat may be taken while it waits.
module firewall_rule_range_match
  import fwrm_pkg::*;
#(
  parameter int unsigned MAX_RULES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  fwrm_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output fwrm_out_t out_data_o
);

  localparam int unsigned CntW  = $clog2(MAX_RULES + 1);
  localparam int unsigned AddrW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_RULES);

  fwrm_state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  fwrm_pkt_t       pkt_q, pkt_d;
  fwrm_out_t       res_q, res_d;
  fwrm_out_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic             accept;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  fwrm_rule_t       wr_rule, rd_rule;
  logic [RuleW-1:0] ram_rdata;
  logic             hit;
  logic             out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign wr_rule.addr_low  = in_data_i.rule_addr_low;
  assign wr_rule.addr_high = in_data_i.rule_addr_high;
  assign wr_rule.port_low  = in_data_i.rule_port_low;
  assign wr_rule.port_high = in_data_i.rule_port_high;
  assign ram_waddr         = count_q[AddrW-1:0];
  assign rd_rule           = fwrm_rule_t'(ram_rdata);

  fwrm_ram #(
    .Width (RuleW),
    .Depth (MAX_RULES)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_rule),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fwrm_match u_match (
    .rule_i (rd_rule),
    .pkt_i  (pkt_q),
    .hit_o  (hit)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    pkt_d       = pkt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = rd_idx_q[AddrW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d.reject     = 1'b0;
          res_d.table_full = 1'b0;
          state_d          = ST_DONE;
          case (fwrm_func_e'(in_data_i.func))
            FUNC_CLEAR: begin
              count_d = '0;
            end
            FUNC_ADD: begin
              if (count_q == CntMax) begin
                res_d.table_full = 1'b1;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            FUNC_CHECK: begin
              pkt_d.addr = in_data_i.pkt_addr;
              pkt_d.port = in_data_i.pkt_port;
              if (count_q != '0) begin
                // issue the first rule read now, data arrives in the first scan cycle
                ram_re    = 1'b1;
                ram_raddr = '0;
                rd_idx_d  = CntW'(1);
                state_d   = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
          res_d.rules_held = RulesHeldW'(count_d);
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_d.reject = 1'b1;
          state_d      = ST_DONE;
        end else if (rd_idx_q == count_q) begin
          state_d = ST_DONE;
        end else begin
          ram_re   = 1'b1;
          rd_idx_d = rd_idx_q + 1'b1;
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pkt_q <= pkt_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("rule count beyond capacity");

  a_scan_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rd_idx_q != '0) && (rd_idx_q <= count_q))
    else $error("scan index outside stored rules");

  a_add_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.func == FUNC_ADD) && (count_q != CntMax))
      |=> (count_q == $past(count_q) + 1'b1))
    else $error("add did not grow the table");

  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.reject && out_q.table_full))
    else $error("reject and table_full both set");

endmodule
